// ===== src/joystick_deadzone_power_curve_core_defines.svh =====
// Assertion macros shared by the joystick dead zone curve RTL.
`ifndef JOYSTICK_DEADZONE_POWER_CURVE_CORE_DEFINES_SVH
`define JOYSTICK_DEADZONE_POWER_CURVE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low.
`define JDPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, quiet while rst_n is low.
`define JDPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jdpc_pkg.sv =====
// Constants, payload types and log2/exp2 tables of the joystick curve core.
`default_nettype none

package jdpc_pkg;

    localparam int OUT_FRAC_BITS   = 8;
    localparam int LOG_TABLE_DEPTH = 256;
    localparam int IDX_W           = $clog2(LOG_TABLE_DEPTH);

    localparam int STICK_W = 8;
    localparam int DZ_W    = 7;
    localparam int EXP_W   = 12;
    localparam int OUT_W   = 16;
    localparam int MAG_W   = 7;
    localparam int LOG2_W  = 19;
    localparam int T_W     = 24;
    localparam int Q_W     = T_W - 16;
    localparam int ET_W    = 17;
    localparam int SCL_W   = 23;
    localparam int SUM_W   = 50;
    localparam int SHIFT_W = 6;

    localparam logic [MAG_W-1:0]   PCT_FULL = 7'd100;
    localparam logic [DZ_W-1:0]    DZ_MAX   = 7'd99;
    localparam logic [Q_W-1:0]     Q_MAX    = 8'd32;
    localparam logic [SHIFT_W-1:0] Q_BASE   = 6'd16;
    localparam logic [31:0]        RND_HALF = 32'd128;
    localparam logic [OUT_W-2:0]   MAG_SAT  = 15'h7FFF;

    localparam int OUT_MAX = ((100 << OUT_FRAC_BITS) > 32767) ? 32767
                                                               : (100 << OUT_FRAC_BITS);

    localparam logic [EXP_W-1:0] EXP_RESET = 12'd256;
    localparam logic [DZ_W-1:0]  DZ_RESET  = 7'd0;

    typedef enum logic {
        REG_DEADBAND  = 1'b0,
        REG_CURVE_EXP = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              neg;
        logic              zero;
        logic [LOG2_W-1:0] diff;
    } jdpc_log_t;

    typedef struct packed {
        logic           neg;
        logic           zero;
        logic [T_W-1:0] t;
    } jdpc_prod_t;

    typedef struct packed {
        logic            neg;
        logic            zero;
        logic [Q_W-1:0]  q;
        logic [ET_W-1:0] et;
    } jdpc_exp_t;

    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [Q_W-1:0]   q;
        logic [SCL_W-1:0] scl;
    } jdpc_scl_t;

    typedef logic [63:0]       cst_arr_t [16];
    typedef logic [LOG2_W-1:0] log2_tab_t [2**MAG_W];
    typedef logic [ET_W-1:0]   exp_tab_t [LOG_TABLE_DEPTH];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bval;
        v   = v_in;
        res = '0;
        for (int n = 0; n < 32; n++) begin
            bval = 64'd1 << (62 - 2 * n);
            if (v >= res + bval) begin
                v   = v - (res + bval);
                res = (res >> 1) + bval;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    function automatic cst_arr_t exp_consts();
        cst_arr_t c;
        c[0] = int_sqrt(64'd1 << 59);
        for (int b = 1; b < 16; b++) begin
            c[b] = int_sqrt(c[b-1] << 30);
        end
        return c;
    endfunction

    // Fraction bits of log2 of 1 + i/depth, by repeated squaring.
    function automatic logic [15:0] log_frac(input int i);
        logic [63:0] x;
        logic [15:0] acc;
        x   = ((64'd1 << 30) * 64'(LOG_TABLE_DEPTH + i)) / LOG_TABLE_DEPTH;
        acc = '0;
        for (int b = 0; b < 16; b++) begin
            x   = (x * x) >> 30;
            acc = acc << 1;
            if (x >= (64'd1 << 31)) begin
                acc[0] = 1'b1;
                x      = x >> 1;
            end
        end
        return acc;
    endfunction

    // 2^-(i/depth) in Q16, rounded.
    function automatic logic [ET_W-1:0] exp_entry(input int i);
        cst_arr_t    c;
        logic [63:0] f;
        logic [63:0] p;
        c = exp_consts();
        f = (64'(i) << 16) / LOG_TABLE_DEPTH;
        p = 64'd1 << 30;
        for (int b = 0; b < 16; b++) begin
            if (f[15-b]) begin
                p = (p * c[b]) >> 30;
            end
        end
        return ET_W'((p + (64'd1 << 13)) >> 14);
    endfunction

    // log2(n) in Q16 for a 7-bit integer; zero maps to zero.
    function automatic logic [LOG2_W-1:0] log2_entry(input int n);
        int          k;
        logic [63:0] fr;
        logic [63:0] idx;
        logic [63:0] sum;
        k = 0;
        for (int b = 1; b < MAG_W; b++) begin
            if ((n >> b) != 0) begin
                k = b;
            end
        end
        fr  = ((64'(n) << 16) >> k) - 64'd65536;
        idx = (fr * LOG_TABLE_DEPTH) >> 16;
        if (idx >= 64'(LOG_TABLE_DEPTH)) begin
            idx = 64'(LOG_TABLE_DEPTH - 1);
        end
        sum = (64'(k) << 16) + 64'(log_frac(int'(idx)));
        if (n == 0) begin
            sum = '0;
        end
        return LOG2_W'(sum);
    endfunction

    function automatic log2_tab_t build_log2_tab();
        log2_tab_t tab;
        for (int n = 0; n < 2**MAG_W; n++) begin
            tab[n] = log2_entry(n);
        end
        return tab;
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t tab;
        for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
            tab[i] = exp_entry(i);
        end
        return tab;
    endfunction

    localparam log2_tab_t LOG2_TAB = build_log2_tab();
    localparam exp_tab_t  EXP_TAB  = build_exp_tab();

endpackage

`default_nettype wire

// ===== src/jdpc_log.sv =====
// Stage 1: stick magnitude, dead zone test and log2 difference of the ratio.
`default_nettype none

module jdpc_log (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [7:0]            stick_position,
    input  wire logic [jdpc_pkg::DZ_W-1:0]    deadband,
    output logic                              log_valid,
    input  wire logic                         log_ready,
    output jdpc_pkg::jdpc_log_t               log_data
);
    import jdpc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    jdpc_log_t         data_reg;
    jdpc_log_t         data_next;
    logic [7:0]        mag8;
    logic [MAG_W-1:0]  mag;
    logic [DZ_W-1:0]   dz;
    logic [MAG_W-1:0]  num;
    logic [MAG_W-1:0]  den;
    logic [LOG2_W-1:0] lnum;
    logic [LOG2_W-1:0] lden;

    assign in_ready  = !valid_reg || log_ready;
    assign log_valid = valid_reg;
    assign log_data  = data_reg;

    always_comb
    begin
        mag8 = stick_position[7] ? (8'(~stick_position) + 8'd1) : 8'(stick_position);
        mag  = (mag8 > 8'(PCT_FULL)) ? PCT_FULL : mag8[MAG_W-1:0];
        dz   = (deadband > DZ_MAX) ? DZ_MAX : deadband;
        num  = mag - dz;
        den  = PCT_FULL - dz;
        lnum = LOG2_TAB[num];
        lden = LOG2_TAB[den];

        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready)
        begin
            data_next.neg  = stick_position[7];
            data_next.zero = (mag <= dz);
            data_next.diff = (lden > lnum) ? (lden - lnum) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== src/jdpc_pow.sv =====
// Stages 2 and 3: scale the log2 difference by the exponent, then exp2 lookup.
`default_nettype none

module jdpc_pow (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [jdpc_pkg::EXP_W-1:0]   curve_exponent,
    input  wire logic                         log_valid,
    output logic                              log_ready,
    input  wire jdpc_pkg::jdpc_log_t          log_data,
    output logic                              exp_valid,
    input  wire logic                         exp_ready,
    output jdpc_pkg::jdpc_exp_t               exp_data
);
    import jdpc_pkg::*;

    localparam int JPROD_W = 16 + IDX_W + 1;

    logic               prod_valid_reg;
    logic               prod_valid_next;
    jdpc_prod_t         prod_reg;
    jdpc_prod_t         prod_next;
    logic               prod_ready;
    logic               exp_valid_reg;
    logic               exp_valid_next;
    jdpc_exp_t          exp_reg;
    jdpc_exp_t          exp_next;
    logic [31:0]        t_full;
    logic [JPROD_W-1:0] jprod;
    logic [IDX_W-1:0]   j;

    assign prod_ready = !exp_valid_reg || exp_ready;
    assign log_ready  = !prod_valid_reg || prod_ready;
    assign exp_valid  = exp_valid_reg;
    assign exp_data   = exp_reg;

    // Stage 2: t = round(exponent * diff / 256), Q16.
    always_comb
    begin
        t_full = ((32'(curve_exponent) * 32'(log_data.diff)) + RND_HALF) >> 8;

        prod_valid_next = prod_valid_reg;
        prod_next       = prod_reg;
        if (log_ready)
        begin
            prod_valid_next = log_valid;
        end
        if (log_valid && log_ready)
        begin
            prod_next.neg  = log_data.neg;
            prod_next.zero = log_data.zero;
            prod_next.t    = t_full[T_W-1:0];
        end
    end

    // Stage 3: split t into integer shift and table index.
    always_comb
    begin
        jprod = JPROD_W'(prod_reg.t[15:0]) * JPROD_W'(LOG_TABLE_DEPTH);
        j     = jprod[16 +: IDX_W];

        exp_valid_next = exp_valid_reg;
        exp_next       = exp_reg;
        if (prod_ready)
        begin
            exp_valid_next = prod_valid_reg;
        end
        if (prod_valid_reg && prod_ready)
        begin
            exp_next.neg  = prod_reg.neg;
            exp_next.zero = prod_reg.zero;
            exp_next.q    = prod_reg.t[T_W-1:16];
            exp_next.et   = EXP_TAB[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            exp_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            exp_valid_reg  <= exp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        exp_reg  <= exp_next;
    end

endmodule

`default_nettype wire

// ===== src/jdpc_out.sv =====
// Stages 4 and 5: scale to percent, round-shift, saturate and restore sign.
`default_nettype none

module jdpc_out (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          exp_valid,
    output logic                               exp_ready,
    input  wire jdpc_pkg::jdpc_exp_t           exp_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [jdpc_pkg::OUT_W-1:0]  curved_value
);
    import jdpc_pkg::*;

    logic                     scl_valid_reg;
    logic                     scl_valid_next;
    jdpc_scl_t                scl_reg;
    jdpc_scl_t                scl_next;
    logic                     scl_ready;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    logic signed [OUT_W-1:0]  res_reg;
    logic signed [OUT_W-1:0]  res_next;
    logic [SHIFT_W-1:0]       shamt;
    logic [SUM_W-1:0]         sum;
    logic [SUM_W-1:0]         res_full;
    logic [OUT_W-2:0]         mag;

    assign scl_ready    = !res_valid_reg || out_ready;
    assign exp_ready    = !scl_valid_reg || scl_ready;
    assign out_valid    = res_valid_reg;
    assign curved_value = res_reg;

    // Stage 4: 100 * exp2 value.
    always_comb
    begin
        scl_valid_next = scl_valid_reg;
        scl_next       = scl_reg;
        if (exp_ready)
        begin
            scl_valid_next = exp_valid;
        end
        if (exp_valid && exp_ready)
        begin
            scl_next.neg  = exp_data.neg;
            scl_next.zero = exp_data.zero;
            scl_next.q    = exp_data.q;
            scl_next.scl  = SCL_W'(exp_data.et) * SCL_W'(PCT_FULL);
        end
    end

    // Stage 5: shift right by 16 + q with round half up; drop shifts beyond 48.
    always_comb
    begin
        shamt    = Q_BASE + SHIFT_W'(scl_reg.q);
        sum      = (SUM_W'(scl_reg.scl) << OUT_FRAC_BITS)
                 + (SUM_W'(1) << (shamt - SHIFT_W'(1)));
        res_full = sum >> shamt;
        if (scl_reg.zero || (scl_reg.q > Q_MAX))
        begin
            mag = '0;
        end
        else if (res_full > SUM_W'(MAG_SAT))
        begin
            mag = MAG_SAT;
        end
        else
        begin
            mag = res_full[OUT_W-2:0];
        end

        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (scl_ready)
        begin
            res_valid_next = scl_valid_reg;
        end
        if (scl_valid_reg && scl_ready)
        begin
            res_next = scl_reg.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            scl_valid_reg <= scl_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scl_reg <= scl_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ===== src/joystick_deadzone_power_curve_core.sv =====
// Joystick dead zone and power curve core: one stick sample in, one shaped
// value out. The datapath is a five-stage pipeline (log2 lookup of the dead
// zone ratio, exponent multiply, exp2 lookup, scale by 100, round-shift and
// sign) that accepts one transaction per clock when the output is not
// stalled; a stall at the output backs up stage by stage, so the input
// ready drops only once all five stages hold data. Results keep input
// order. The output is signed Q8.8 percent. deadband (offset 0x0) and
// curve_exponent (offset 0x4, unsigned Q4.8, reset 1.0) are written over
// the APB port; change them only while no transaction is in flight. Dead
// zone values above 99 act as 99.
`default_nettype none

`include "joystick_deadzone_power_curve_core_defines.svh"

module joystick_deadzone_power_curve_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [7:0]             stick_position,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [jdpc_pkg::OUT_W-1:0]  curved_value
);
    import jdpc_pkg::*;

    logic [DZ_W-1:0]  deadband_reg;
    logic [DZ_W-1:0]  deadband_next;
    logic [EXP_W-1:0] curve_exponent_reg;
    logic [EXP_W-1:0] curve_exponent_next;
    logic             cfg_write;
    reg_idx_t         reg_idx;

    logic      log_valid;
    logic      log_ready;
    jdpc_log_t log_data;
    logic      exp_valid;
    logic      exp_ready;
    jdpc_exp_t exp_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = reg_idx_t'(paddr[2]);

    always_comb
    begin
        deadband_next       = deadband_reg;
        curve_exponent_next = curve_exponent_reg;
        prdata              = '0;
        case (reg_idx)
            REG_DEADBAND:
            begin
                prdata = 32'(deadband_reg);
                if (cfg_write)
                begin
                    deadband_next = pwdata[DZ_W-1:0];
                end
            end
            REG_CURVE_EXP:
            begin
                prdata = 32'(curve_exponent_reg);
                if (cfg_write)
                begin
                    curve_exponent_next = pwdata[EXP_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg       <= DZ_RESET;
            curve_exponent_reg <= EXP_RESET;
        end
        else
        begin
            deadband_reg       <= deadband_next;
            curve_exponent_reg <= curve_exponent_next;
        end
    end

    jdpc_log u_log (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stick_position (stick_position),
        .deadband       (deadband_reg),
        .log_valid      (log_valid),
        .log_ready      (log_ready),
        .log_data       (log_data)
    );

    jdpc_pow u_pow (
        .clk            (clk),
        .rst_n          (rst_n),
        .curve_exponent (curve_exponent_reg),
        .log_valid      (log_valid),
        .log_ready      (log_ready),
        .log_data       (log_data),
        .exp_valid      (exp_valid),
        .exp_ready      (exp_ready),
        .exp_data       (exp_data)
    );

    jdpc_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .exp_valid    (exp_valid),
        .exp_ready    (exp_ready),
        .exp_data     (exp_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .curved_value (curved_value)
    );

    // Input backpressure only when every stage is full and the output is held.
    `JDPC_ASSERT_SAME(a_stall_needs_full_pipe, !in_ready, out_valid && !out_ready, "input stalled with room in the pipeline")
    `JDPC_ASSERT_NEXT(a_deadband_write, cfg_write && (reg_idx == REG_DEADBAND), deadband_reg == $past(pwdata[DZ_W-1:0]), "deadband write lost")
    `JDPC_ASSERT_SAME(a_out_in_range, out_valid, ($signed(curved_value) <= OUT_MAX) && ($signed(curved_value) >= -OUT_MAX), "curved_value beyond full scale")

endmodule

`default_nettype wire

// ===== tb/curve_checker.sv =====
// Checker for the joystick curve core: predicts each shaped value and compares it.
`timescale 1ns / 100ps

module curve_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [7:0]                        stick_position,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [jdpc_pkg::OUT_W-1:0] curved_value,
    output int                                errors,
    output int                                pending
);
    import jdpc_pkg::*;

    logic [15:0]      log2_frac_lut [LOG_TABLE_DEPTH];
    logic [16:0]      exp2_lut [LOG_TABLE_DEPTH];
    logic [63:0]      half_pow [16];
    logic [DZ_W-1:0]  dz_cfg  = DZ_RESET;
    logic [EXP_W-1:0] exp_cfg = EXP_RESET;
    logic [OUT_W-1:0] curve_q [$];
    logic [OUT_W-1:0] want;
    int               err_cnt = 0;

    initial errors = 0;
    initial pending = 0;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] probe;
        v     = v_in;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Build the log2 fraction and exp2 tables once, before the first edge.
    initial begin
        logic [63:0] x;
        logic [63:0] f;
        logic [63:0] p;
        logic [15:0] acc;
        half_pow[0] = isqrt64(64'd1 << 59);
        for (int b = 1; b < 16; b++)
            half_pow[b] = isqrt64(half_pow[b-1] << 30);
        for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
            x   = ((64'd1 << 30) * 64'(LOG_TABLE_DEPTH + i)) / 64'(LOG_TABLE_DEPTH);
            acc = '0;
            for (int b = 0; b < 16; b++) begin
                x   = (x * x) >> 30;
                acc = acc << 1;
                if (x >= (64'd1 << 31)) begin
                    acc[0] = 1'b1;
                    x      = x >> 1;
                end
            end
            log2_frac_lut[i] = acc;
            f = (64'(i) << 16) / 64'(LOG_TABLE_DEPTH);
            p = 64'd1 << 30;
            for (int b = 0; b < 16; b++) begin
                if (f[15-b])
                    p = (p * half_pow[b]) >> 30;
            end
            exp2_lut[i] = 17'((p + (64'd1 << 13)) >> 14);
        end
    end

    // log2 of a small integer, Q16
    function automatic logic [63:0] log2_fix(input int n);
        int          k;
        logic [63:0] fr;
        logic [63:0] idx;
        k = 0;
        while (k < 31 && (n >> (k + 1)) != 0)
            k++;
        fr  = ((64'(n) << 16) >> k) - 64'd65536;
        idx = (fr * 64'(LOG_TABLE_DEPTH)) >> 16;
        if (idx >= 64'(LOG_TABLE_DEPTH))
            idx = 64'(LOG_TABLE_DEPTH - 1);
        return (64'(k) << 16) + 64'(log2_frac_lut[int'(idx)]);
    endfunction

    function automatic logic [OUT_W-1:0] shape_stick(input logic [7:0] raw,
                                                     input logic [DZ_W-1:0] dz_reg,
                                                     input logic [EXP_W-1:0] expo);
        logic        neg;
        int          mag;
        int          dz;
        logic [63:0] lnum;
        logic [63:0] lden;
        logic [63:0] t;
        logic [63:0] j;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] res;
        neg = raw[7];
        mag = neg ? 256 - int'(raw) : int'(raw);
        dz  = (dz_reg > DZ_MAX) ? int'(DZ_MAX) : int'(dz_reg);
        if (mag > 100)
            mag = 100;
        if (mag <= dz)
            return '0;
        lnum = log2_fix(mag - dz);
        lden = log2_fix(100 - dz);
        t    = (lden > lnum) ? lden - lnum : 64'd0;
        t    = (64'(expo) * t + 64'd128) >> 8;
        j    = ((t & 64'hFFFF) * 64'(LOG_TABLE_DEPTH)) >> 16;
        if (j >= 64'(LOG_TABLE_DEPTH))
            j = 64'(LOG_TABLE_DEPTH - 1);
        s = 64'd16 + (t >> 16);
        if (s > 64'd48) begin
            res = '0;
        end else begin
            v   = (64'd100 * 64'(exp2_lut[int'(j)])) << OUT_FRAC_BITS;
            res = (v + (64'd1 << (s - 1))) >> s;
        end
        if (res > 64'd32767)
            res = 64'd32767;
        if (neg)
            res = 64'd0 - res;
        return res[OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dz_cfg  = DZ_RESET;
            exp_cfg = EXP_RESET;
            curve_q.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[2]))
                    REG_DEADBAND:  dz_cfg  = pwdata[DZ_W-1:0];
                    REG_CURVE_EXP: exp_cfg = pwdata[EXP_W-1:0];
                    default: ;
                endcase
            end
            // compare the outgoing transaction before queuing the incoming one
            if (out_valid && out_ready) begin
                if (curve_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: curved_value expected none actual %0d", $time,
                             curved_value);
                end else begin
                    want = curve_q.pop_front();
                    if (curved_value !== want) begin
                        err_cnt++;
                        $display("%0t: curved_value expected %0d actual %0d", $time,
                                 $signed(want), curved_value);
                    end
                end
            end
            if (in_valid && in_ready)
                curve_q.push_back(shape_stick(stick_position, dz_cfg, exp_cfg));
            errors  <= err_cnt;
            pending <= curve_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the joystick curve testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import jdpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    psel           = 1'b0;
    logic                    penable        = 1'b0;
    logic                    pwrite         = 1'b0;
    logic [2:0]              paddr          = '0;
    logic [31:0]             pwdata         = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid       = 1'b0;
    logic                    in_ready;
    logic signed [7:0]       stick_position = '0;
    logic                    out_valid;
    logic                    out_ready      = 1'b0;
    logic signed [OUT_W-1:0] curved_value;

    int errors;
    int pending;
    int cycle_cnt      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    joystick_deadzone_power_curve_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stick_position (stick_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .curved_value   (curved_value)
    );

    curve_checker u_curve_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stick_position (stick_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .curved_value   (curved_value),
        .errors         (errors),
        .pending        (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Write both registers back to back, keeping psel high between them.
    task automatic set_config(input logic [DZ_W-1:0] dz, input logic [EXP_W-1:0] expo);
        reg_idx_t idx;
        for (int r = 0; r < 2; r++) begin
            idx = (r == 0) ? REG_DEADBAND : REG_CURVE_EXP;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= (idx == REG_DEADBAND) ? 32'(dz) : 32'(expo);
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold valid across back-to-back transactions; drop it only for a gap.
    task automatic push_stick(input logic [7:0] v);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid       <= 1'b1;
        stick_position <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] rand_stick(input int dz);
        int          pick;
        int          mag;
        logic [7:0]  v;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 8'(int'($urandom_range(0, 200)) - 100);
        if (pick < 8)
            return 8'($urandom);
        case ($urandom_range(0, 4))
            0:       mag = dz;
            1:       mag = dz + 1;
            2:       mag = 100;
            3:       mag = 127;
            default: mag = 128;
        endcase
        v = 8'(mag);
        if ($urandom_range(0, 1) != 0)
            v = -v;
        return v;
    endfunction

    initial begin
        int               dir_vals [$];
        logic [DZ_W-1:0]  dz_w;
        logic [EXP_W-1:0] exp_w;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: saturation, dead zone edges, zero and max exponent
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    set_config(7'd0, 12'd256);
                    dir_vals = '{-128, -101, -100, -99, -1, 0, 1, 50, 99, 100, 101, 127};
                end
                1: begin
                    set_config(7'd10, 12'd0);
                    dir_vals = '{10, 11, -10, -11, 127};
                end
                2: begin
                    set_config(7'd127, 12'd4095);
                    dir_vals = '{99, 100, -100, -128};
                end
                default: begin
                    set_config(7'd0, 12'd4095);
                    dir_vals = '{1, -1, 2, -2};
                end
            endcase
            foreach (dir_vals[i])
                push_stick(8'(dir_vals[i]));
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin dz_w = 7'd0;   exp_w = 12'd4095; end
                1: begin dz_w = 7'd99;  exp_w = 12'd0;    end
                2: begin dz_w = 7'd127; exp_w = 12'd1;    end
                3: begin dz_w = 7'd1;   exp_w = 12'd2048; end
                default: begin
                    dz_w  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(0, 60));
                    exp_w = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 4095))
                                                        : 12'($urandom_range(64, 768));
                end
            endcase
            set_config(dz_w, exp_w);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            repeat (180)
                push_stick(rand_stick(int'(dz_w)));
            drain();
        end

        // let any stray result surface past the pipeline depth
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
